### rtl/i2c_ras_pkg.sv
`default_nettype none

package i2c_ras_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] OP_WRITE_REQ = 2'd0;
    localparam logic [1:0] OP_READ_REQ  = 2'd1;
    localparam logic [1:0] OP_BYTE_DONE = 2'd2;

    // Transmit kinds on the output channel
    localparam logic [1:0] TX_NONE    = 2'd0;
    localparam logic [1:0] TX_START   = 2'd1;
    localparam logic [1:0] TX_RESTART = 2'd2;
    localparam logic [1:0] TX_DATA    = 2'd3;

    // Acknowledge modes for the receiver
    localparam logic [1:0] ACK_KEEP = 2'd0;
    localparam logic [1:0] ACK_ON   = 2'd1;
    localparam logic [1:0] ACK_NAK  = 2'd2;

    // Sequence phase
    typedef enum logic [2:0] {
        PH_REG     = 3'd0,
        PH_RESTART = 3'd1,
        PH_READ    = 3'd2,
        PH_WRITE1  = 3'd3,
        PH_WRITE2  = 3'd4
    } phase_t;

    // One input item
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] slave_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       bus_busy;
        logic       ack_received;
        logic [7:0] rx_byte;
    } item_t;

    // One result item
    typedef struct packed {
        logic       accepted;
        logic [1:0] tx_kind;
        logic [7:0] tx_byte;
        logic       stop_cond;
        logic [1:0] ack_mode;
        logic       rx_trigger;
        logic       store_valid;
        logic [7:0] store_byte;
        logic       busy_res;
        logic       done_res;
        logic       error;
    } result_t;

    // Sequencer state
    typedef struct packed {
        phase_t     phase;
        logic [8:0] remaining;
        logic       busy_flag;
        logic       done_flag;
        logic       error_flag;
        logic       is_write;
        logic [7:0] saved_device;
        logic [7:0] saved_register;
        logic [7:0] saved_data;
        logic [7:0] saved_count;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        phase:          PH_REG,
        remaining:      9'd0,
        busy_flag:      1'b0,
        done_flag:      1'b0,
        error_flag:     1'b0,
        is_write:       1'b0,
        saved_device:   8'd0,
        saved_register: 8'd0,
        saved_data:     8'd0,
        saved_count:    8'd0
    };

endpackage

`default_nettype wire

### rtl/i2c_ras_step.sv
`default_nettype none

module i2c_ras_step
(
    input  wire  i2c_ras_pkg::item_t      item,
    input  wire  i2c_ras_pkg::seq_state_t cur,
    output i2c_ras_pkg::seq_state_t       nxt,
    output i2c_ras_pkg::result_t          res
);

    logic [8:0] count_plus_one;
    logic [8:0] rem_dec;
    logic       finish;
    logic       finish_err;

    assign count_plus_one = {1'b0, cur.saved_count} + 9'd1;
    assign rem_dec        = cur.remaining - 9'd1;

    // Sequence step: request handling and byte-done event handling
    always_comb
    begin
        nxt        = cur;
        res        = '0;
        finish     = 1'b0;
        finish_err = 1'b0;

        if ((item.op == i2c_ras_pkg::OP_WRITE_REQ) || (item.op == i2c_ras_pkg::OP_READ_REQ))
        begin
            if (!item.bus_busy && !cur.busy_flag)
            begin
                nxt.saved_device   = item.slave_addr;
                nxt.saved_register = item.reg_addr;
                nxt.is_write       = (item.op == i2c_ras_pkg::OP_WRITE_REQ);
                if (item.op == i2c_ras_pkg::OP_WRITE_REQ)
                begin
                    nxt.saved_data = item.write_data;
                end
                else
                begin
                    nxt.saved_count = item.read_count;
                end
                nxt.busy_flag  = 1'b1;
                nxt.error_flag = 1'b0;
                nxt.done_flag  = 1'b0;
                nxt.phase      = i2c_ras_pkg::PH_REG;
                res.accepted   = 1'b1;
                res.tx_kind    = i2c_ras_pkg::TX_START;
                res.tx_byte    = item.slave_addr;
            end
        end
        else if ((item.op == i2c_ras_pkg::OP_BYTE_DONE) && cur.busy_flag)
        begin
            unique case (cur.phase)
                i2c_ras_pkg::PH_RESTART:
                begin
                    if (!item.ack_received)
                    begin
                        finish     = 1'b1;
                        finish_err = 1'b1;
                    end
                    else
                    begin
                        res.tx_kind   = i2c_ras_pkg::TX_RESTART;
                        res.tx_byte   = cur.saved_device | 8'h01;
                        res.ack_mode  = i2c_ras_pkg::ACK_ON;
                        nxt.remaining = count_plus_one;
                        nxt.phase     = i2c_ras_pkg::PH_READ;
                    end
                end
                i2c_ras_pkg::PH_READ:
                begin
                    // The read address ack is only seen on the first read event.
                    if ((cur.remaining == count_plus_one) && !item.ack_received)
                    begin
                        finish     = 1'b1;
                        finish_err = 1'b1;
                    end
                    else
                    begin
                        if (cur.remaining != 9'd0)
                        begin
                            nxt.remaining  = rem_dec;
                            res.rx_trigger = 1'b1;
                            if (rem_dec == 9'd1)
                            begin
                                res.ack_mode = i2c_ras_pkg::ACK_NAK;
                            end
                            // The first receive is the dummy read and delivers nothing.
                            if (rem_dec != {1'b0, cur.saved_count})
                            begin
                                res.store_valid = 1'b1;
                                res.store_byte  = item.rx_byte;
                            end
                        end
                        if (nxt.remaining == 9'd0)
                        begin
                            finish = 1'b1;
                        end
                    end
                end
                i2c_ras_pkg::PH_WRITE1:
                begin
                    if (!item.ack_received)
                    begin
                        finish     = 1'b1;
                        finish_err = 1'b1;
                    end
                    else
                    begin
                        res.tx_kind = i2c_ras_pkg::TX_DATA;
                        res.tx_byte = cur.saved_data;
                        nxt.phase   = i2c_ras_pkg::PH_WRITE2;
                    end
                end
                i2c_ras_pkg::PH_WRITE2:
                begin
                    finish     = 1'b1;
                    finish_err = !item.ack_received;
                end
                default:
                begin
                    if (!item.ack_received)
                    begin
                        finish     = 1'b1;
                        finish_err = 1'b1;
                    end
                    else
                    begin
                        res.tx_kind = i2c_ras_pkg::TX_DATA;
                        res.tx_byte = cur.saved_register;
                        nxt.phase   = cur.is_write ? i2c_ras_pkg::PH_WRITE1
                                                   : i2c_ras_pkg::PH_RESTART;
                    end
                end
            endcase

            // End of transaction: stop and return to idle
            if (finish)
            begin
                nxt.phase      = i2c_ras_pkg::PH_REG;
                nxt.busy_flag  = 1'b0;
                nxt.done_flag  = 1'b1;
                nxt.error_flag = finish_err;
                res.stop_cond  = 1'b1;
            end
        end

        res.busy_res = nxt.busy_flag;
        res.done_res = nxt.done_flag;
        res.error    = nxt.error_flag;
    end

endmodule

`default_nettype wire

### rtl/i2c_register_access_sequencer.sv
// Channel  Direction  Contents
// s_axis   in         tuser: op; tdata: request fields and byte-done event fields
// m_axis   out        tuser: tx_kind; tdata: one result per input item
//
// Every input item gives exactly one result via the input and result
// registers. One item is taken per cycle while the output is not stalled:
// the input register feeds the sequence step logic, which writes the result
// register and the sequencer state in the same cycle. A stall on the output
// holds the result and the input register; s_tready drops only when both
// are full. rst_n clears the sequencer to idle and empties both registers.
`default_nettype none

module i2c_register_access_sequencer
(
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_tvalid,
    output logic        s_tready,
    // [7:0] slave_addr, [15:8] reg_addr, [23:16] write_data, [31:24] read_count,
    // [32] bus_busy, [33] ack_received, [41:34] rx_byte, [47:42] zero
    input  wire  [47:0] s_tdata,
    // [1:0] op
    input  wire  [1:0]  s_tuser,

    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] accepted, [8:1] tx_byte, [9] stop_cond, [11:10] ack_mode,
    // [12] rx_trigger, [13] store_valid, [21:14] store_byte, [22] busy_res,
    // [23] done_res, [24] error, [31:25] zero
    output logic [31:0] m_tdata,
    // [1:0] tx_kind
    output logic [1:0]  m_tuser
);

    logic                    in_valid_reg;
    i2c_ras_pkg::item_t      in_item_reg;
    i2c_ras_pkg::item_t      in_item_next;
    logic                    out_valid_reg;
    i2c_ras_pkg::result_t    out_res_reg;
    i2c_ras_pkg::result_t    step_res;
    i2c_ras_pkg::seq_state_t state_reg;
    i2c_ras_pkg::seq_state_t state_next;
    logic                    advance;

    // The input register moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Unpack the input transfer
    always_comb
    begin
        in_item_next.op           = s_tuser;
        in_item_next.slave_addr   = s_tdata[7:0];
        in_item_next.reg_addr     = s_tdata[15:8];
        in_item_next.write_data   = s_tdata[23:16];
        in_item_next.read_count   = s_tdata[31:24];
        in_item_next.bus_busy     = s_tdata[32];
        in_item_next.ack_received = s_tdata[33];
        in_item_next.rx_byte      = s_tdata[41:34];
    end

    i2c_ras_step u_step
    (
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // Valid flags and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= i2c_ras_pkg::STATE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_next;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    // Pack the result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.tx_kind;
    assign m_tdata  = {7'd0,
                       out_res_reg.error,
                       out_res_reg.done_res,
                       out_res_reg.busy_res,
                       out_res_reg.store_byte,
                       out_res_reg.store_valid,
                       out_res_reg.rx_trigger,
                       out_res_reg.ack_mode,
                       out_res_reg.stop_cond,
                       out_res_reg.tx_byte,
                       out_res_reg.accepted};

endmodule

`default_nettype wire

### rtl/i2c_ras_checker.sv
`default_nettype none

module i2c_ras_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // A stalled result must hold its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // A transaction cannot be in progress and done at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[22] && m_tdata[23]))
        else $error("busy and done both set");

    // An error is only reported for a finished transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[24]) |-> m_tdata[23])
        else $error("error without done");

    // An accepted request starts with a start condition and leaves the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> ((m_tuser == i2c_ras_pkg::TX_START) && m_tdata[22]))
        else $error("accepted request without start");

    // A delivered byte always comes with a receive trigger.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13]) |-> m_tdata[12])
        else $error("stored byte without receive");

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_i2c_ras_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### sim/i2c_register_access_sequencer_tb.sv
`timescale 1ns / 1ps

module i2c_register_access_sequencer_tb;

    // The input channel can carry this op code, but the sequencer ignores it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int STALL_LIMIT  = 1000;
    localparam int ITEM_TARGET  = 1100;
    localparam int PAUSE_STRIDE = 300;
    localparam int DRAIN_CYCLES = 8;

    // One entry of the stimulus queue. A hold entry holds the sender back
    // until every outstanding result has arrived.
    typedef struct {
        bit                 hold;
        i2c_ras_pkg::item_t it;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    stim_t                   pending[$];
    i2c_ras_pkg::result_t    expected_results[$];
    i2c_ras_pkg::seq_state_t model_state = i2c_ras_pkg::STATE_RESET;

    int          stim_total = 0;
    int          seq_items = 0;
    int          items_taken = 0;
    int          outstanding = 0;
    int          stall_cycles = 0;
    int          mismatch_count = 0;
    int          result_index = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    bit          sender_calm = 1'b0;
    bit          receiver_calm = 1'b0;

    i2c_register_access_sequencer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Sequencer prediction: one input item in, exactly one result out.
    task automatic advance_sequence(input i2c_ras_pkg::item_t it,
                                    output i2c_ras_pkg::result_t r);
        bit end_now;
        bit end_err;
        end_now = 1'b0;
        end_err = 1'b0;
        r = '0;
        if (it.op == i2c_ras_pkg::OP_WRITE_REQ || it.op == i2c_ras_pkg::OP_READ_REQ)
        begin
            if (!it.bus_busy && !model_state.busy_flag)
            begin
                model_state.saved_device   = it.slave_addr;
                model_state.saved_register = it.reg_addr;
                model_state.is_write       = (it.op == i2c_ras_pkg::OP_WRITE_REQ);
                if (model_state.is_write)
                    model_state.saved_data = it.write_data;
                else
                    model_state.saved_count = it.read_count;
                model_state.busy_flag  = 1'b1;
                model_state.error_flag = 1'b0;
                model_state.done_flag  = 1'b0;
                model_state.phase      = i2c_ras_pkg::PH_REG;
                r.accepted = 1'b1;
                r.tx_kind  = i2c_ras_pkg::TX_START;
                r.tx_byte  = model_state.saved_device;
            end
        end
        else if (it.op == i2c_ras_pkg::OP_BYTE_DONE && model_state.busy_flag)
        begin
            case (model_state.phase)
                i2c_ras_pkg::PH_RESTART:
                begin
                    if (!it.ack_received)
                    begin
                        end_now = 1'b1;
                        end_err = 1'b1;
                    end
                    else
                    begin
                        r.tx_kind = i2c_ras_pkg::TX_RESTART;
                        r.tx_byte = model_state.saved_device | 8'h01;
                        r.ack_mode = i2c_ras_pkg::ACK_ON;
                        model_state.remaining = {1'b0, model_state.saved_count} + 9'd1;
                        model_state.phase = i2c_ras_pkg::PH_READ;
                    end
                end
                i2c_ras_pkg::PH_READ:
                begin
                    // The read address ack is only seen on the first event here.
                    if (model_state.remaining == {1'b0, model_state.saved_count} + 9'd1
                        && !it.ack_received)
                    begin
                        end_now = 1'b1;
                        end_err = 1'b1;
                    end
                    else
                    begin
                        if (model_state.remaining != 9'd0)
                        begin
                            model_state.remaining = model_state.remaining - 9'd1;
                            if (model_state.remaining == 9'd1)
                                r.ack_mode = i2c_ras_pkg::ACK_NAK;
                            r.rx_trigger = 1'b1;
                            // The first byte after the repeated start is a dummy read.
                            if (model_state.remaining != {1'b0, model_state.saved_count})
                            begin
                                r.store_valid = 1'b1;
                                r.store_byte  = it.rx_byte;
                            end
                        end
                        if (model_state.remaining == 9'd0)
                            end_now = 1'b1;
                    end
                end
                i2c_ras_pkg::PH_WRITE1:
                begin
                    if (!it.ack_received)
                    begin
                        end_now = 1'b1;
                        end_err = 1'b1;
                    end
                    else
                    begin
                        r.tx_kind = i2c_ras_pkg::TX_DATA;
                        r.tx_byte = model_state.saved_data;
                        model_state.phase = i2c_ras_pkg::PH_WRITE2;
                    end
                end
                i2c_ras_pkg::PH_WRITE2:
                begin
                    end_now = 1'b1;
                    end_err = !it.ack_received;
                end
                default:
                begin
                    if (!it.ack_received)
                    begin
                        end_now = 1'b1;
                        end_err = 1'b1;
                    end
                    else
                    begin
                        r.tx_kind = i2c_ras_pkg::TX_DATA;
                        r.tx_byte = model_state.saved_register;
                        model_state.phase = model_state.is_write ? i2c_ras_pkg::PH_WRITE1
                                                                 : i2c_ras_pkg::PH_RESTART;
                    end
                end
            endcase
        end

        // Completion, with or without an error, issues a stop and goes idle.
        if (end_now)
        begin
            model_state.phase      = i2c_ras_pkg::PH_REG;
            model_state.busy_flag  = 1'b0;
            model_state.done_flag  = 1'b1;
            model_state.error_flag = end_err;
            r.stop_cond = 1'b1;
        end
        r.busy_res = model_state.busy_flag;
        r.done_res = model_state.done_flag;
        r.error    = model_state.error_flag;
    endtask

    function automatic string result_text(i2c_ras_pkg::result_t r);
        return $sformatf("acc=%0b kind=%0d byte=%02h stop=%0b ackm=%0d rxt=%0b %s",
                         r.accepted, r.tx_kind, r.tx_byte, r.stop_cond, r.ack_mode,
                         r.rx_trigger,
                         $sformatf("sv=%0b sb=%02h busy=%0b done=%0b err=%0b",
                                   r.store_valid, r.store_byte, r.busy_res,
                                   r.done_res, r.error));
    endfunction

    // Gap or stall length for one transfer; a calm side never waits.
    function automatic int draw_pause(bit calm);
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic i2c_ras_pkg::item_t random_item();
        i2c_ras_pkg::item_t it;
        it.op           = 2'($urandom);
        it.slave_addr   = 8'($urandom);
        it.reg_addr     = 8'($urandom);
        it.write_data   = 8'($urandom);
        it.read_count   = 8'($urandom);
        it.bus_busy     = 1'($urandom);
        it.ack_received = 1'($urandom);
        it.rx_byte      = 8'($urandom);
        return it;
    endfunction

    task automatic push_item(i2c_ras_pkg::item_t it);
        stim_t s;
        s.hold = 1'b0;
        s.it   = it;
        pending.push_back(s);
        stim_total++;
    endtask

    task automatic pause_for_results();
        stim_t s;
        s.hold = 1'b1;
        s.it   = '0;
        pending.push_back(s);
    endtask

    task automatic push_request(logic [1:0] op, logic [7:0] dev, logic [7:0] regi,
                                logic [7:0] data, logic [7:0] count, bit bus_busy);
        i2c_ras_pkg::item_t it;
        it = random_item();
        it.op          = op;
        it.slave_addr  = dev;
        it.reg_addr    = regi;
        it.write_data  = data;
        it.read_count  = count;
        it.bus_busy    = bus_busy;
        push_item(it);
    endtask

    task automatic push_event(bit ack, logic [7:0] rx);
        i2c_ras_pkg::item_t it;
        it = random_item();
        it.op           = i2c_ras_pkg::OP_BYTE_DONE;
        it.ack_received = ack;
        it.rx_byte      = rx;
        push_item(it);
    endtask

    // Items that the sequencer refuses or ignores inside a transaction; events
    // only when allowed, since an event inside a transaction would advance it.
    task automatic push_noise(bit allow_events);
        i2c_ras_pkg::item_t it;
        int                 pick;
        pick = allow_events ? int'($urandom_range(0, 3)) : int'($urandom_range(0, 2));
        it = random_item();
        case (pick)
            0: it.op = OP_UNUSED;
            1: it.op = $urandom_range(0, 1) ? i2c_ras_pkg::OP_WRITE_REQ
                                            : i2c_ras_pkg::OP_READ_REQ;
            2:
            begin
                it.op = $urandom_range(0, 1) ? i2c_ras_pkg::OP_WRITE_REQ
                                             : i2c_ras_pkg::OP_READ_REQ;
                it.bus_busy = 1'b1;
            end
            default: ;
        endcase
        push_item(it);
    endtask

    // A request and the byte-done events that carry it to the end. The event
    // numbered miss_at carries no ack and ends the transaction.
    task automatic run_transaction(bit write_op, logic [7:0] dev, logic [7:0] regi,
                                   logic [7:0] data, logic [7:0] count, int miss_at,
                                   logic [7:0] rx_base, bit poke_busy, int noise_pct);
        int n_events;
        int e;
        bit ack;
        n_events = write_op ? 3 : int'(count) + 3;
        push_request(write_op ? i2c_ras_pkg::OP_WRITE_REQ : i2c_ras_pkg::OP_READ_REQ,
                     dev, regi, data, count, 1'b0);
        seq_items++;
        if (poke_busy)
            push_request(i2c_ras_pkg::OP_WRITE_REQ, 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 1'b0);
        for (e = 0; e < n_events; e++)
        begin
            if (int'($urandom_range(0, 99)) < noise_pct)
                push_noise(1'b0);
            if (e == miss_at)
                ack = 1'b0;
            else if (e < 3)
                ack = 1'b1;
            else
                ack = 1'($urandom);
            push_event(ack, rx_base ^ (e[0] ? 8'hFF : 8'h00));
            seq_items++;
            if (e == miss_at)
                break;
        end
    endtask

    // Sender: one item on the bus at a time, with a drawn gap after each transfer.
    always @(posedge clk or negedge rst_n)
    begin
        bit    next_valid;
        stim_t cur;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_wait = 0;
        end
        else
        begin
            next_valid = s_tvalid && !s_tready;
            if (!next_valid)
            begin
                if (send_wait != 0)
                    send_wait = send_wait - 1;
                else if (pending.size() != 0)
                begin
                    if (pending[0].hold)
                    begin
                        if (!s_tvalid && outstanding == 0)
                            cur = pending.pop_front();
                    end
                    else
                    begin
                        cur = pending.pop_front();
                        s_tdata <= {6'd0, cur.it.rx_byte, cur.it.ack_received,
                                    cur.it.bus_busy, cur.it.read_count, cur.it.write_data,
                                    cur.it.reg_addr, cur.it.slave_addr};
                        s_tuser <= cur.it.op;
                        next_valid = 1'b1;
                        if ($urandom_range(0, 39) == 0)
                            sender_calm = !sender_calm;
                        send_wait = draw_pause(sender_calm);
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver and checker: predicts on each input transfer and compares
    // each output transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        i2c_ras_pkg::item_t   got_item;
        i2c_ras_pkg::result_t seen;
        i2c_ras_pkg::result_t want;
        bit                   in_x;
        bit                   out_x;
        if (!rst_n)
        begin
            m_tready     <= 1'b0;
            outstanding  <= 0;
            items_taken  <= 0;
            stall_cycles <= 0;
            recv_wait = 0;
            model_state = i2c_ras_pkg::STATE_RESET;
            expected_results.delete();
        end
        else
        begin
            in_x  = s_tvalid && s_tready;
            out_x = m_tvalid && m_tready;

            if (in_x)
            begin
                got_item.op           = s_tuser;
                got_item.slave_addr   = s_tdata[7:0];
                got_item.reg_addr     = s_tdata[15:8];
                got_item.write_data   = s_tdata[23:16];
                got_item.read_count   = s_tdata[31:24];
                got_item.bus_busy     = s_tdata[32];
                got_item.ack_received = s_tdata[33];
                got_item.rx_byte      = s_tdata[41:34];
                advance_sequence(got_item, want);
                expected_results.push_back(want);
            end

            if (out_x)
            begin
                seen.accepted    = m_tdata[0];
                seen.tx_kind     = m_tuser;
                seen.tx_byte     = m_tdata[8:1];
                seen.stop_cond   = m_tdata[9];
                seen.ack_mode    = m_tdata[11:10];
                seen.rx_trigger  = m_tdata[12];
                seen.store_valid = m_tdata[13];
                seen.store_byte  = m_tdata[21:14];
                seen.busy_res    = m_tdata[22];
                seen.done_res    = m_tdata[23];
                seen.error       = m_tdata[24];
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result %0d arrived with no prediction pending: %s",
                                 result_index, result_text(seen));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want || m_tdata[31:25] !== 7'd0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("Result %0d differs", result_index);
                            $display("  expected %s pad=00", result_text(want));
                            $display("  actual   %s pad=%02h", result_text(seen),
                                     m_tdata[31:25]);
                        end
                    end
                end
                result_index++;
                if ($urandom_range(0, 39) == 0)
                    receiver_calm = !receiver_calm;
                recv_wait = draw_pause(receiver_calm);
            end
            else if (recv_wait != 0)
                recv_wait = recv_wait - 1;

            m_tready     <= (recv_wait == 0);
            outstanding  <= outstanding + int'(in_x) - int'(out_x);
            items_taken  <= items_taken + int'(in_x);
            stall_cycles <= (in_x || out_x) ? 0 : stall_cycles + 1;
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus, then the end of the run.
    initial
    begin
        int pick;
        int miss_at;
        int count;
        int next_pause;

        // Ignored and refused items while idle.
        push_event(1'b1, 8'h5A);
        push_request(OP_UNUSED, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        push_request(i2c_ras_pkg::OP_WRITE_REQ, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // Complete write to device FE with register and data FF.
        run_transaction(1'b1, 8'hFE, 8'hFF, 8'hFF, 8'h00, -1, 8'h00, 1'b0, 0);
        // Zero read count: only the dummy read, then stop.
        run_transaction(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, -1, 8'h00, 1'b0, 0);
        // Two-byte read, refused request in the middle, bytes 00 and FF stored.
        run_transaction(1'b0, 8'hA4, 8'h5A, 8'h00, 8'h02, -1, 8'hFF, 1'b1, 0);
        // Missing ack on the read address.
        run_transaction(1'b0, 8'h3C, 8'hC3, 8'h00, 8'h01, 2, 8'h00, 1'b0, 0);
        // Missing ack on the device address of a write.
        run_transaction(1'b1, 8'h42, 8'h24, 8'h99, 8'h00, 0, 8'h00, 1'b0, 0);
        pause_for_results();

        // Mostly well-formed transactions with random content, plus noise.
        next_pause = seq_items + PAUSE_STRIDE;
        while (seq_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            miss_at = -1;
            if ($urandom_range(0, 7) == 0)
                miss_at = $urandom_range(0, 2);
            if (pick < 40)
            begin
                run_transaction(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), miss_at, 8'($urandom),
                                ($urandom_range(0, 7) == 0), 8);
            end
            else if (pick < 85)
            begin
                count = $urandom_range(0, 99);
                if (count < 2)
                    count = 255;
                else if (count < 12)
                    count = $urandom_range(7, 40);
                else
                    count = $urandom_range(0, 6);
                run_transaction(1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'(count), miss_at, 8'($urandom),
                                ($urandom_range(0, 7) == 0), 8);
            end
            else
                push_noise(1'b1);
            if (seq_items >= next_pause)
            begin
                pause_for_results();
                next_pause = next_pause + PAUSE_STRIDE;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken != stim_total)
            @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/i2c_ras_pkg.sv
rtl/i2c_ras_step.sv
rtl/i2c_register_access_sequencer.sv
rtl/i2c_ras_checker.sv
sim/i2c_register_access_sequencer_tb.sv
